[hdl/tsa_pkg.sv]
`default_nettype none
package tsa_pkg;

  localparam int SIDE_DEF   = 64;
  localparam int SLOT_W     = 12;
  localparam int COORD_W    = 6;
  localparam int WORD_W     = 32;
  localparam int FREE_DEPTH = 4096;
  localparam int FREE_PTR_W = $clog2(FREE_DEPTH);
  localparam int FREE_CNT_W = $clog2(FREE_DEPTH + 1);

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic STAT_GRANT = 1'b0;
  localparam logic STAT_NONE  = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } fl_status_t;

  // what the allocator decided for one allocate beat
  typedef struct packed {
    logic fail;       // no fresh slot and free list empty
    logic from_list;  // slot comes from the free list read port
  } slot_req_t;

endpackage
`default_nettype wire

[hdl/tsa_free_list.sv]
`default_nettype none
module tsa_free_list
  import tsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [SLOT_W-1:0] push_data,
  input  wire logic              pop,
  output logic      [SLOT_W-1:0] pop_data,
  output fl_status_t             status
);

  logic [SLOT_W-1:0]     mem [FREE_DEPTH];
  logic [SLOT_W-1:0]     pop_data_r;
  logic [FREE_PTR_W-1:0] head_r, head_nxt;
  logic [FREE_PTR_W-1:0] tail_r, tail_nxt;
  logic [FREE_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    head_nxt  = pop  ? head_r + 1'b1 : head_r;
    tail_nxt  = push ? tail_r + 1'b1 : tail_r;
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // read data holds until the next pop
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= push_data;
    end
    if (pop) begin
      pop_data_r <= mem[head_r];
    end
  end

  assign pop_data     = pop_data_r;
  assign status.full  = (count_r == FREE_CNT_W'(FREE_DEPTH));
  assign status.empty = (count_r == '0);

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty) else $error("free list popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full) else $error("free list pushed while full");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (status.empty || status.full) |-> (head_r == tail_r))
    else $error("free list pointers disagree with count");
`endif

endmodule
`default_nettype wire

[hdl/tsa_slot_split.sv]
`default_nettype none
module tsa_slot_split
  import tsa_pkg::*;
#(
  parameter int SIDE = SIDE_DEF,
  parameter int ID_W = SLOT_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire slot_req_t         req,
  input  wire logic [ID_W-1:0]   fresh_id,
  input  wire logic [SLOT_W-1:0] list_id,
  input  wire logic [WORD_W-1:0] req_colour,
  input  wire logic [WORD_W-1:0] req_normal,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic                   res_status,
  output logic [SLOT_W-1:0]      res_slot,
  output logic [COORD_W-1:0]     res_column,
  output logic [COORD_W-1:0]     res_row,
  output logic [WORD_W-1:0]      res_colour,
  output logic [WORD_W-1:0]      res_normal
);

  // quotient by reciprocal: q = (id * ceil(2^SH / SIDE)) >> SH, exact for all id < 2^ID_W
  localparam int LOG_SIDE = $clog2(SIDE);
  localparam int SH       = ID_W + LOG_SIDE;
  localparam int MUL_W    = ID_W + 2;
  localparam int MUL_I    = ((1 << SH) + SIDE - 1) / SIDE;
  localparam logic [MUL_W-1:0] MUL = MUL_W'(MUL_I);

  logic                    s2_valid_r;
  logic                    s2_fail_r;
  logic [ID_W-1:0]         s2_id_r;
  logic [ID_W-1:0]         s2_quo_r;
  logic [WORD_W-1:0]       s2_colour_r;
  logic [WORD_W-1:0]       s2_normal_r;

  logic                    res_valid_r;
  logic                    res_status_r;
  logic [SLOT_W-1:0]       res_slot_r;
  logic [COORD_W-1:0]      res_column_r;
  logic [COORD_W-1:0]      res_row_r;
  logic [WORD_W-1:0]       res_colour_r;
  logic [WORD_W-1:0]       res_normal_r;

  logic                    res_en;
  logic                    s2_ready;
  logic [ID_W-1:0]         id_sel;
  logic [ID_W+MUL_W-1:0]   prod;
  logic [2*ID_W-1:0]       quo_scaled;
  logic [ID_W-1:0]         rem;

  assign res_en    = !res_valid_r || res_ready;
  assign s2_ready  = !s2_valid_r || res_en;
  assign req_ready = s2_ready;

  assign id_sel     = req.from_list ? ID_W'(list_id) : fresh_id;
  assign prod       = id_sel * MUL;
  assign quo_scaled = s2_quo_r * ID_W'(SIDE);
  assign rem        = s2_id_r - quo_scaled[ID_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= req_valid;
      end
      if (res_en) begin
        res_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && req_valid) begin
      s2_fail_r   <= req.fail;
      s2_id_r     <= id_sel;
      s2_quo_r    <= ID_W'(prod >> SH);
      s2_colour_r <= req_colour;
      s2_normal_r <= req_normal;
    end
    if (res_en && s2_valid_r) begin
      if (s2_fail_r) begin
        res_status_r <= STAT_NONE;
        res_slot_r   <= '0;
        res_column_r <= '0;
        res_row_r    <= '0;
        res_colour_r <= '0;
        res_normal_r <= '0;
      end else begin
        res_status_r <= STAT_GRANT;
        res_slot_r   <= s2_id_r[SLOT_W-1:0];
        res_column_r <= rem[COORD_W-1:0];
        res_row_r    <= s2_quo_r[COORD_W-1:0];
        res_colour_r <= s2_colour_r;
        res_normal_r <= s2_normal_r;
      end
    end
  end

  assign res_valid  = res_valid_r;
  assign res_status = res_status_r;
  assign res_slot   = res_slot_r;
  assign res_column = res_column_r;
  assign res_row    = res_row_r;
  assign res_colour = res_colour_r;
  assign res_normal = res_normal_r;

endmodule
`default_nettype wire

[hdl/texel_slot_allocator.sv]
// Texel slot allocator for a SIDE x SIDE atlas; slot 0 only after a release.
// Input channel (in_valid/in_ready): in_command selects allocate or release.
//   Allocate takes the next fresh slot while any remain, then the oldest
//   released slot from a 4096-entry free list, else reports exhaustion.
//   Release queues in_release_slot; it is dropped when the list is full
//   and produces no result beat.
// Result channel (out_valid/out_ready): one beat per allocate with status,
//   slot, column, row and the colour/normal words to write there.
// Path: a beat passes the request register (free-list read), the reciprocal
//   multiply for row, then remainder into the output register.
// Throughput: one beat per cycle each way while out_ready holds; allocator
//   state updates at acceptance, so back-to-back allocates and releases work.
// Stalls: each of the three stages holds its beat while the one after it
//   is full, so input is still taken while a result waits in the output
//   register as long as an earlier stage has room.
// Reset: counters and valids clear, the fresh counter restarts at 1 and the
//   free list is empty; its storage is not cleared and needs no init pass.
`default_nettype none
module texel_slot_allocator
  import tsa_pkg::*;
#(
  parameter int SIDE = SIDE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_command,
  input  wire logic [WORD_W-1:0] in_colour_word,
  input  wire logic [WORD_W-1:0] in_normal_word,
  input  wire logic [SLOT_W-1:0] in_release_slot,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_status,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [COORD_W-1:0]     out_column,
  output logic [COORD_W-1:0]     out_row,
  output logic [WORD_W-1:0]      out_texel_colour,
  output logic [WORD_W-1:0]      out_texel_normal
);

  localparam int TOTAL   = SIDE * SIDE;
  localparam int FRESH_W = $clog2(TOTAL + 1);
  localparam int ID_W    = ($clog2(TOTAL) > SLOT_W) ? $clog2(TOTAL) : SLOT_W;

  logic [FRESH_W-1:0] fresh_r, fresh_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  slot_req_t          s1_req_r;
  logic [ID_W-1:0]    s1_id_r;
  logic [WORD_W-1:0]  s1_colour_r;
  logic [WORD_W-1:0]  s1_normal_r;

  logic               s1_ready;
  logic               accept;
  logic               is_alloc;
  logic               fresh_left;
  logic               fresh_take;
  logic               fl_push;
  logic               fl_pop;
  logic [SLOT_W-1:0]  fl_pop_data;
  fl_status_t         fl_status;

  assign in_ready   = !s1_valid_r || s1_ready;
  assign accept     = in_valid && in_ready;
  assign is_alloc   = (in_command == CMD_ALLOC);
  assign fresh_left = (fresh_r < FRESH_W'(TOTAL));
  assign fresh_take = accept && is_alloc && fresh_left;
  assign fl_pop     = accept && is_alloc && !fresh_left && !fl_status.empty;
  assign fl_push    = accept && (in_command == CMD_RELEASE) && !fl_status.full;

  always_comb begin
    fresh_nxt    = fresh_take ? fresh_r + 1'b1 : fresh_r;
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = is_alloc;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r    <= FRESH_W'(1);
      s1_valid_r <= 1'b0;
    end else begin
      fresh_r    <= fresh_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_alloc) begin
      s1_req_r.fail      <= !fresh_left && fl_status.empty;
      s1_req_r.from_list <= !fresh_left;
      s1_id_r            <= ID_W'(fresh_r);
      s1_colour_r        <= in_colour_word;
      s1_normal_r        <= in_normal_word;
    end
  end

  tsa_free_list u_free_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fl_push),
    .push_data (in_release_slot),
    .pop       (fl_pop),
    .pop_data  (fl_pop_data),
    .status    (fl_status)
  );

  tsa_slot_split #(
    .SIDE (SIDE),
    .ID_W (ID_W)
  ) u_slot_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (s1_valid_r),
    .req_ready  (s1_ready),
    .req        (s1_req_r),
    .fresh_id   (s1_id_r),
    .list_id    (fl_pop_data),
    .req_colour (s1_colour_r),
    .req_normal (s1_normal_r),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res_status (out_status),
    .res_slot   (out_slot),
    .res_column (out_column),
    .res_row    (out_row),
    .res_colour (out_texel_colour),
    .res_normal (out_texel_normal)
  );

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
  import tsa_pkg::*;

  localparam int ATLAS_SLOTS = SIDE_DEF * SIDE_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 850;

  typedef struct packed {
    logic              command;
    logic [WORD_W-1:0] colour;
    logic [WORD_W-1:0] normal;
    logic [SLOT_W-1:0] slot;
  } texel_cmd_t;

  typedef struct packed {
    logic               status;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [WORD_W-1:0]  colour;
    logic [WORD_W-1:0]  normal;
  } texel_grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = CMD_ALLOC;
  logic [WORD_W-1:0] in_colour_word = '0;
  logic [WORD_W-1:0] in_normal_word = '0;
  logic [SLOT_W-1:0] in_release_slot = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [COORD_W-1:0] out_column;
  logic [COORD_W-1:0] out_row;
  logic [WORD_W-1:0] out_texel_colour;
  logic [WORD_W-1:0] out_texel_normal;

  texel_cmd_t   cmd_queue[$];
  texel_grant_t grants_due[$];
  int total_items = 0;
  int beats_in = 0;
  int fail_count = 0;
  int stall_cycles = 0;

  // allocator shadow state
  logic [12:0]            fresh_id = 13'd1;
  logic [SLOT_W-1:0]      free_ring[FREE_DEPTH];
  logic [FREE_PTR_W-1:0]  free_rd = '0;
  logic [FREE_PTR_W-1:0]  free_wr = '0;
  logic [FREE_CNT_W-1:0]  listed_cnt = '0;

  texel_slot_allocator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_colour_word   (in_colour_word),
    .in_normal_word   (in_normal_word),
    .in_release_slot  (in_release_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_texel_colour (out_texel_colour),
    .out_texel_normal (out_texel_normal)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_count < 100) begin
      $display("%0t %s: got %0h want %0h", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  task automatic queue_cmd(logic cmd, logic [WORD_W-1:0] colour, logic [WORD_W-1:0] normal,
                           logic [SLOT_W-1:0] slot);
    texel_cmd_t c;
    c.command = cmd;
    c.colour  = colour;
    c.normal  = normal;
    c.slot    = slot;
    cmd_queue = {cmd_queue, c};
  endtask

  task automatic queue_alloc();
    queue_cmd(CMD_ALLOC, $urandom, $urandom, 12'($urandom_range(4095)));
  endtask

  // mostly random slots, with the edges of the atlas mixed in
  task automatic queue_release();
    logic [SLOT_W-1:0] s;
    case ($urandom_range(9))
      0: s = '0;
      1: s = '1;
      2: s = 12'(SIDE_DEF - 1);
      3: s = 12'(SIDE_DEF);
      default: s = 12'($urandom_range(4095));
    endcase
    queue_cmd(CMD_RELEASE, $urandom, $urandom, s);
  endtask

  function automatic void predict_grant(texel_cmd_t c);
    texel_grant_t g;
    logic [SLOT_W-1:0] id;
    g = '0;
    if (c.command == CMD_RELEASE) begin
      // full list drops the beat
      if (listed_cnt < FREE_DEPTH) begin
        free_ring[free_wr] = c.slot;
        free_wr = free_wr + 1'b1;
        listed_cnt = listed_cnt + 1'b1;
      end
      return;
    end
    if (fresh_id < ATLAS_SLOTS) begin
      id = fresh_id[SLOT_W-1:0];
      fresh_id = fresh_id + 1'b1;
    end else if (listed_cnt != 0) begin
      id = free_ring[free_rd];
      free_rd = free_rd + 1'b1;
      listed_cnt = listed_cnt - 1'b1;
    end else begin
      g.status = STAT_NONE;
      grants_due = {grants_due, g};
      return;
    end
    g.status = STAT_GRANT;
    g.slot   = id;
    g.column = COORD_W'(id % SIDE_DEF);
    g.row    = COORD_W'(id / SIDE_DEF);
    g.colour = c.colour;
    g.normal = c.normal;
    grants_due = {grants_due, g};
  endfunction

  function automatic int idle_pct(bit for_sender);
    if (beats_in * 3 < total_items) return for_sender ? 24 : 72;
    if (beats_in * 3 < total_items * 2) return for_sender ? 72 : 24;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin : cmd_driver
    texel_cmd_t c;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_grant({in_command, in_colour_word, in_normal_word, in_release_slot});
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          c = cmd_queue.pop_front();
          in_valid        <= 1'b1;
          in_command      <= c.command;
          in_colour_word  <= c.colour;
          in_normal_word  <= c.normal;
          in_release_slot <= c.slot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= idle_pct(1'b0));
  end

  // monitor
  always @(posedge clk) begin : grant_monitor
    texel_grant_t want;
    if (rst_n && out_valid && out_ready) begin
      if (grants_due.size() == 0) begin
        report_mismatch("result beat with nothing pending, slot", out_slot, 0);
      end else begin
        want = grants_due.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_slot !== want.slot)
          report_mismatch("slot", out_slot, want.slot);
        if (out_column !== want.column)
          report_mismatch("column", out_column, want.column);
        if (out_row !== want.row)
          report_mismatch("row", out_row, want.row);
        if (out_texel_colour !== want.colour)
          report_mismatch("texel_colour", out_texel_colour, want.colour);
        if (out_texel_normal !== want.normal)
          report_mismatch("texel_normal", out_texel_normal, want.normal);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    // directed: word extremes, odd releases (slot 0, top slot, repeats)
    queue_cmd(CMD_ALLOC, '0, '0, '0);
    queue_cmd(CMD_ALLOC, '1, '1, '1);
    queue_cmd(CMD_ALLOC, '0, '1, 12'h555);
    queue_cmd(CMD_ALLOC, '1, '0, 12'hAAA);
    queue_cmd(CMD_RELEASE, '1, '1, '0);
    queue_cmd(CMD_RELEASE, '0, '0, '1);
    queue_cmd(CMD_RELEASE, 32'hA5A5A5A5, 32'h5A5A5A5A, 12'hAAA);
    queue_cmd(CMD_RELEASE, 32'h5A5A5A5A, 32'hA5A5A5A5, 12'h555);
    queue_cmd(CMD_RELEASE, '0, '0, 12'd1);
    queue_cmd(CMD_RELEASE, '0, '0, 12'd1);
    queue_cmd(CMD_RELEASE, '0, '0, 12'(SIDE_DEF - 1));
    queue_cmd(CMD_RELEASE, '0, '0, 12'(SIDE_DEF));
    queue_cmd(CMD_ALLOC, 32'h80000001, 32'h7FFFFFFE, '0);
    queue_cmd(CMD_ALLOC, 32'h7FFFFFFE, 32'h80000001, '0);

    // mixed allocate and release traffic
    while (cmd_queue.size() < ITEM_TARGET) begin
      if ($urandom_range(99) < 55) queue_release();
      else queue_alloc();
    end

    total_items = cmd_queue.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || in_valid || grants_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (grants_due.size() != 0)
      report_mismatch("results never delivered", grants_due.size(), 0);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/tsa_pkg.sv
hdl/tsa_free_list.sv
hdl/tsa_slot_split.sv
hdl/texel_slot_allocator.sv
verif/tb_top.sv
